>>> rtl/core/ahm_pkg.sv
`timescale 1ns / 1ps
// Package for the address keyed hash map unit: sizes, status codes,
// transaction types and the bucket row layout. It depends on nothing else.
package ahm_pkg;

    // Table geometry. BUCKETS must be a power of two between 16 and 65536.
    localparam int BUCKETS  = 256;
    localparam int WAYS     = 4;
    localparam int BUCKET_W = $clog2(BUCKETS);
    localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;

    // Fixed field widths.
    localparam int ADDR_W      = 64;
    localparam int OBJ_W       = 64;
    localparam int STATUS_W    = 3;
    localparam int ENTRY_CNT_W = 11;
    localparam int IGNORE_W    = 6;
    localparam int INDEX_W     = 4;
    localparam int MASK_W      = 16;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 6;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_IGNORE_BITS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS  = 1'd1;

    localparam logic [IGNORE_W-1:0] IGNORE_RESET = 6'd0;
    localparam logic [INDEX_W-1:0]  INDEX_RESET  = 4'd8;
    localparam logic [INDEX_W-1:0]  INDEX_MIN    = 4'd4;

    // Operation kinds.
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_SAME     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_CONFLICT = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_MISS     = 3'd4;
    localparam logic [STATUS_W-1:0] ST_HIT      = 3'd5;

    typedef struct packed {
        logic              kind;
        logic [ADDR_W-1:0] key_addr;
        logic [OBJ_W-1:0]  obj_handle;
    } req_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [OBJ_W-1:0]       found_obj;
        logic [ENTRY_CNT_W-1:0] entry_count;
    } rsp_item_t;

    // One bucket as stored in the table memory.
    typedef struct packed {
        logic [WAYS-1:0]             valid;
        logic [WAYS-1:0][ADDR_W-1:0] key;
        logic [WAYS-1:0][OBJ_W-1:0]  obj;
    } row_t;

    localparam int ROW_W = $bits(row_t);

endpackage

>>> rtl/core/ahm_ram.sv
`timescale 1ns / 1ps
// Generic single-clock RAM with one write port and one registered read port.
// It depends on nothing else.
module ahm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/core/address_keyed_hash_map_unit.sv
`timescale 1ns / 1ps
// Top level of the address keyed hash map unit.
// Depends on ahm_pkg and ahm_ram.
//
// Usage:
// The block maps 64-bit addresses to 64-bit object handles. A request
// transaction (req_valid, req_stall, req) carries an insert or a lookup;
// a response transaction (rsp_valid, rsp_stall, rsp) returns exactly one
// status, the found handle on a lookup hit and the entry count after the
// operation. A transaction moves at a rising edge with valid high and
// stall low.
// Each request passes an accept stage and a compare stage: in the accept
// cycle the bucket index is formed and the bucket row is read from the
// table memory; in the compare stage the ways are compared in parallel
// and, once the output register is free, the row is written back on an
// insert and the response is loaded into the output register. No new
// request is taken until the compare stage has passed its response on.
// A new request is taken while a finished response still waits in the
// output register; if the receiver keeps stalling, the second request is
// held in the compare stage until the output register frees up.
// Reset clears all bucket valid flags, the entry count and the response
// valid flag, and loads ignore_bits = 0 and index_bits = 8. The table is
// usable as soon as reset is released; no clearing pass is needed.
// Configuration writes are taken on any cycle with cfg_write high.
module address_keyed_hash_map_unit
    import ahm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  req_valid,
    output logic                  req_stall,
    input  req_item_t             req,
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output rsp_item_t             rsp
);

    // Configuration registers.
    logic [IGNORE_W-1:0] ignore_bits_reg;
    logic [INDEX_W-1:0]  index_bits_reg;

    // Control state.
    logic                   busy_reg;
    logic                   busy_next;
    logic                   rsp_valid_reg;
    logic                   rsp_valid_next;
    logic [BUCKETS-1:0]     row_valid_reg;
    logic [ENTRY_CNT_W-1:0] held_count_reg;
    logic [ENTRY_CNT_W-1:0] held_count_next;

    // Request held for the compare stage.
    req_item_t            item_reg;
    logic [BUCKET_W-1:0]  bucket_reg;
    rsp_item_t            rsp_reg;
    rsp_item_t            rsp_next;

    // Accept stage signals.
    logic                 accept;
    logic [ADDR_W-1:0]    shifted;
    logic [INDEX_W-1:0]   eff_index;
    logic [MASK_W-1:0]    index_mask;
    logic [BUCKET_W-1:0]  bucket_next;

    // Compare stage signals.
    logic                 fire;
    row_t                 row_rd;
    row_t                 row_wr;
    logic [WAYS-1:0]      way_valid;
    logic [WAYS-1:0]      way_match;
    logic                 any_match;
    logic                 any_free;
    logic [WAY_W-1:0]     match_way;
    logic [WAYS-1:0]      free_onehot;
    logic [OBJ_W-1:0]     match_obj;
    logic                 do_insert;
    logic [ROW_W-1:0]     row_rd_bits;

    // One request in flight at a time; the compare stage holds it until the
    // output register can take its response.
    assign accept    = req_valid && !busy_reg;
    assign req_stall = busy_reg;
    assign fire      = busy_reg && (!rsp_valid_reg || !rsp_stall);

    assign busy_next      = accept || (busy_reg && !fire);
    assign rsp_valid_next = fire || (rsp_valid_reg && rsp_stall);

    // Bucket index: drop the ignored low bits, keep index_bits bits (at least
    // four) and wrap to the table size by taking the low bucket bits.
    assign shifted     = req.key_addr >> ignore_bits_reg;
    assign eff_index   = (index_bits_reg < INDEX_MIN) ? INDEX_MIN : index_bits_reg;
    assign index_mask  = MASK_W'(({1'b0, {MASK_W{1'b0}}} | (17'd1 << eff_index)) - 17'd1);
    assign bucket_next = BUCKET_W'(shifted[MASK_W-1:0] & index_mask);

    ahm_ram #(
        .WIDTH (ROW_W),
        .DEPTH (BUCKETS)
    ) u_table (
        .clk   (clk),
        .we    (do_insert),
        .waddr (bucket_reg),
        .wdata (row_wr),
        .re    (accept),
        .raddr (bucket_next),
        .rdata (row_rd_bits)
    );

    assign row_rd = row_t'(row_rd_bits);

    // Compare all ways of the bucket. A bucket that was never written reads
    // as empty whatever the memory holds.
    always_comb
    begin
        way_valid   = row_rd.valid & {WAYS{row_valid_reg[bucket_reg]}};
        way_match   = '0;
        match_way   = '0;
        free_onehot = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            way_match[w] = way_valid[w] && (row_rd.key[w] == item_reg.key_addr);
        end
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (way_match[w])
            begin
                match_way = WAY_W'(w);
            end
            if (!way_valid[w])
            begin
                free_onehot = WAYS'(1) << w;
            end
        end
    end

    assign any_match = |way_match;
    assign any_free  = |free_onehot;
    assign match_obj = row_rd.obj[match_way];
    assign do_insert = fire && (item_reg.kind == KIND_INSERT) && !any_match && any_free;

    // Write-back row: the new pair goes into the lowest free way.
    always_comb
    begin
        row_wr       = row_rd;
        row_wr.valid = way_valid | free_onehot;
        for (int w = 0; w < WAYS; w++)
        begin
            if (free_onehot[w])
            begin
                row_wr.key[w] = item_reg.key_addr;
                row_wr.obj[w] = item_reg.obj_handle;
            end
        end
    end

    assign held_count_next = do_insert ? held_count_reg + ENTRY_CNT_W'(1) : held_count_reg;

    always_comb
    begin
        rsp_next.found_obj   = '0;
        rsp_next.entry_count = held_count_next;
        if (item_reg.kind == KIND_LOOKUP)
        begin
            if (any_match)
            begin
                rsp_next.status    = ST_HIT;
                rsp_next.found_obj = match_obj;
            end
            else
            begin
                rsp_next.status = ST_MISS;
            end
        end
        else if (any_match)
        begin
            rsp_next.status = (match_obj == item_reg.obj_handle) ? ST_SAME : ST_CONFLICT;
        end
        else if (any_free)
        begin
            rsp_next.status = ST_INSERTED;
        end
        else
        begin
            rsp_next.status = ST_FULL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ignore_bits_reg <= IGNORE_RESET;
            index_bits_reg  <= INDEX_RESET;
            busy_reg        <= 1'b0;
            rsp_valid_reg   <= 1'b0;
            row_valid_reg   <= '0;
            held_count_reg  <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_IGNORE_BITS: ignore_bits_reg <= cfg_data[IGNORE_W-1:0];
                    CFG_INDEX_BITS:  index_bits_reg  <= cfg_data[INDEX_W-1:0];
                    default:         ignore_bits_reg <= ignore_bits_reg;
                endcase
            end
            busy_reg       <= busy_next;
            rsp_valid_reg  <= rsp_valid_next;
            held_count_reg <= held_count_next;
            if (do_insert)
            begin
                row_valid_reg[bucket_reg] <= 1'b1;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg   <= req;
            bucket_reg <= bucket_next;
        end
        if (fire)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTHESIS
    // A finished compare always leaves a response in the output register.
    a_fire_loads_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> rsp_valid_reg)
        else $error("compare stage finished without a response");

    // The entry count only moves with an insert response.
    a_count_moves_on_insert: assert property (@(posedge clk) disable iff (!rst_n)
        (held_count_reg != $past(held_count_reg)) |->
            (rsp_valid_reg && rsp_reg.status == ST_INSERTED
             && rsp_reg.entry_count == held_count_reg))
        else $error("entry count changed without an insert");

    // Only a lookup hit returns a nonzero handle.
    a_found_only_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_reg.status != ST_HIT) |-> (rsp_reg.found_obj == '0))
        else $error("handle returned on a non-hit response");

    // A response never arrives unless a request was taken before it.
    a_rsp_needs_request: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(busy_reg))
        else $error("response without a request in flight");
`endif

endmodule
